// ===== rtl/text_console_cursor_engine_core_assert.svh =====
// Assertion macros for the console engine files, used by tcce_ctrl.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define TCCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_CELLS = COLUMNS * (ROWS - 1);

  localparam int ADDR_W   = $clog2(CELL_COUNT);
  localparam int POS_W    = $clog2(CELL_COUNT + 1);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int PH_W     = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int CURSOR_W = 11;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;

  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RUN_CHAR    = 2'd0,
    RUN_NEWLINE = 2'd1,
    RUN_TAB     = 2'd2
  } run_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                valid;
    logic [CURSOR_W-1:0] cursor_position;
    logic                echo_valid;
    logic [7:0]          echo_byte;
    logic [CELL_W-1:0]   cell_word;
  } result_t;

endpackage

// ===== rtl/text_console_cursor_engine_core.sv =====
// Text console cursor engine.
// Requests arrive on the s_ channel: s_tuser carries the command (put,
// clear, read, or an unused code) and s_tdata the character and cell index.
// Each request yields exactly one response on the m_ channel carrying the
// linear cursor position, the echoed byte on a put, and the stored cell on
// a read. The color attribute register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the engine is idle, as
// the block does not enforce this itself. A plain put loads its response
// from S_WRITE, a read from S_RDATA after S_READ, and an unused command
// straight from S_IDLE. A newline writes up to COLUMNS cells and a tab up
// to TAB_WIDTH cells, one cell per cycle through the single write port of
// the screen store. A pending scroll first sees the pending row, then
// moves every row up by one and blanks the last row, one copy or blank
// write per cycle; a clear blanks every cell. After rst all ROWS*COLUMNS
// cells (2000 at 80 by 25) are blanked before a request is taken.
// Responses wait in a register; with it full and m_tready low, s_tready is low.
module text_console_cursor_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,  // color_attribute
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // character[7:0], cell_index[18:8], zero fill
  input  logic [1:0]  s_tuser,      // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // cursor_position[10:0], echo_byte[18:11],
                                    // cell_word[34:19], zero fill
  output logic [0:0]  m_tuser       // echo_valid[0]
);
  import tcce_pkg::*;

  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;
  result_t           res;
  logic              out_free;
  cmd_t              in_cmd;

  // Output register: holds one response until the receiver takes it; while
  // it is full and the receiver is slow, no new request is accepted.
  logic [CURSOR_W-1:0] out_cursor;
  logic [7:0]          out_echo_byte;
  logic [CELL_W-1:0]   out_cell;
  logic                out_echo_valid;

  assign out_free = !m_tvalid || m_tready;
  assign in_cmd   = cmd_t'(s_tuser);

  tcce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (in_cmd),
    .in_char     (s_tdata[7:0]),
    .in_index    (s_tdata[18:8]),
    .out_free    (out_free),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  tcce_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_cursor     <= res.cursor_position;
      out_echo_byte  <= res.echo_byte;
      out_cell       <= res.cell_word;
      out_echo_valid <= res.echo_valid;
    end
  end

  assign m_tdata    = {5'd0, out_cell, out_echo_byte, out_cursor};
  assign m_tuser[0] = out_echo_valid;

endmodule

// ===== rtl/tcce_screen_ram.sv =====
module tcce_screen_ram (
  input  logic                               clk,
  input  tcce_pkg::ram_req_t                 req,
  output logic [tcce_pkg::CELL_W-1:0]        rdata
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/tcce_ctrl.sv =====
`include "text_console_cursor_engine_core_assert.svh"

module tcce_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcce_pkg::cmd_t                in_cmd,
  input  logic [7:0]                    in_char,
  input  logic [tcce_pkg::INDEX_W-1:0]  in_index,
  input  logic                          out_free,
  output tcce_pkg::result_t             res,
  output tcce_pkg::ram_req_t            ram_req,
  input  logic [tcce_pkg::CELL_W-1:0]   ram_rdata
);
  import tcce_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CLEAR  = 8'b0000_0100,
    S_WRITE  = 8'b0000_1000,
    S_SCROLL = 8'b0001_0000,
    S_BLANK  = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_RDATA  = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  cnt, cnt_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [COL_W-1:0]   col, col_next;
  logic [PH_W-1:0]    ph, ph_next;
  logic [7:0]         color;
  logic [7:0]         ch, ch_next;
  logic [INDEX_W-1:0] idx, idx_next;
  run_t               kind, kind_next;

  // Write stage: every store write is registered and issued in the cycle after it is decided,
  // so that scroll copies can take their data straight from the read port.
  logic               st_we, st_we_next;
  logic [ADDR_W-1:0]  st_addr, st_addr_next;
  logic               st_from_rd, st_from_rd_next;
  logic [CELL_W-1:0]  st_data, st_data_next;

  logic               accept;
  logic               pending;
  logic [COL_W-1:0]   col_inc;
  logic [PH_W-1:0]    ph_inc;
  logic               run_done;
  logic [7:0]         run_char;

  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign pending  = (pos == POS_W'(CELL_COUNT));

  assign col_inc = (col == COL_W'(COLUMNS - 1)) ? '0 : col + 1'b1;
  assign ph_inc  = ((col == COL_W'(COLUMNS - 1)) || (ph == PH_W'(TAB_WIDTH - 1))) ?
                   '0 : ph + 1'b1;
  assign run_char = (kind == RUN_CHAR) ? ch : CH_SPACE;

  always_comb begin
    case (kind)
      RUN_NEWLINE: run_done = (col_inc == '0);
      RUN_TAB:     run_done = (ph_inc == '0);
      default:     run_done = 1'b1;
    endcase
  end

  always_comb begin
    ram_req.we    = st_we;
    ram_req.waddr = st_addr;
    ram_req.wdata = st_from_rd ? ram_rdata : st_data;
    ram_req.raddr = (state == S_SCROLL) ? ADDR_W'(cnt + COLUMNS) : ADDR_W'(idx);
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pos_next        = pos;
    col_next        = col;
    ph_next         = ph;
    ch_next         = ch;
    idx_next        = idx;
    kind_next       = kind;
    st_we_next      = 1'b0;
    st_addr_next    = cnt;
    st_from_rd_next = 1'b0;
    st_data_next    = {color, CH_SPACE};
    res             = '0;
    res.cursor_position = CURSOR_W'(pos);

    unique case (state)
      S_INIT: begin
        st_we_next   = 1'b1;
        st_data_next = {RESET_COLOR, CH_SPACE};
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ch_next  = in_char;
          idx_next = in_index;
          cnt_next = '0;
          if (in_char == CH_NEWLINE) begin
            kind_next = RUN_NEWLINE;
          end else if (in_char == CH_TAB) begin
            kind_next = RUN_TAB;
          end else begin
            kind_next = RUN_CHAR;
          end
          unique case (in_cmd)
            CMD_PUT:   state_next = S_WRITE;
            CMD_CLEAR: state_next = S_CLEAR;
            CMD_READ:  state_next = S_READ;
            default:   res.valid  = 1'b1;
          endcase
        end
      end
      S_CLEAR: begin
        st_we_next = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          pos_next  = '0;
          col_next  = '0;
          ph_next   = '0;
          res.valid = 1'b1;
          res.cursor_position = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WRITE: begin
        if (pending) begin
          cnt_next   = '0;
          state_next = S_SCROLL;
        end else begin
          st_we_next   = 1'b1;
          st_addr_next = ADDR_W'(pos);
          st_data_next = {color, run_char};
          pos_next     = pos + 1'b1;
          col_next     = col_inc;
          ph_next      = ph_inc;
          if (run_done) begin
            res.valid           = 1'b1;
            res.cursor_position = CURSOR_W'(pos + 1'b1);
            res.echo_valid      = 1'b1;
            res.echo_byte       = ch;
            state_next          = S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        st_we_next      = 1'b1;
        st_from_rd_next = 1'b1;
        if (cnt == ADDR_W'(COPY_CELLS - 1)) begin
          cnt_next   = ADDR_W'(COPY_CELLS);
          state_next = S_BLANK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_BLANK: begin
        st_we_next = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          pos_next   = POS_W'(COPY_CELLS);
          col_next   = '0;
          ph_next    = '0;
          state_next = S_WRITE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_READ: begin
        state_next = S_RDATA;
      end
      S_RDATA: begin
        res.valid = 1'b1;
        if (idx < INDEX_W'(CELL_COUNT)) begin
          res.cell_word = ram_rdata;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      pos   <= '0;
      col   <= '0;
      ph    <= '0;
      color <= RESET_COLOR;
      st_we <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
      col   <= col_next;
      ph    <= ph_next;
      st_we <= st_we_next;
      if (cfg_wr_en) begin
        color <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch         <= ch_next;
    idx        <= idx_next;
    kind       <= kind_next;
    st_addr    <= st_addr_next;
    st_from_rd <= st_from_rd_next;
    st_data    <= st_data_next;
  end

  `TCCE_ASSERT_NOW(a_pos_range, 1'b1, pos <= POS_W'(CELL_COUNT), "cursor beyond pending row")
  `TCCE_ASSERT_NOW(a_pending_col, pending, col == '0, "pending scroll off column zero")
  `TCCE_ASSERT_NOW(a_wr_range, st_we, st_addr < ADDR_W'(CELL_COUNT), "store write out of range")
  `TCCE_ASSERT_NEXT(a_res_idle, res.valid, state == S_IDLE, "result without return to idle")

endmodule
